// ===== rtl/vmt_pkg.sv =====
// ----------------------------------------------------------------------------
// vmt_pkg
// Shared types, widths and register codes for the vertex matrix transform.
// ----------------------------------------------------------------------------
package vmt_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int COORD_W       = 32;
    localparam int NUM_COLS      = 4;
    localparam int NUM_REGS      = 8;
    localparam int REG_SEL_W     = $clog2(NUM_REGS);
    localparam int CFG_INDEX_W   = 4;
    localparam int CFG_DATA_W    = 2 * COORD_W;
    localparam int PROD_W        = 2 * COORD_W;
    localparam int PAIR_W        = PROD_W + 1;
    localparam int SUM_W         = PROD_W + 2;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef coord_t [NUM_COLS-1:0] vec4_t;

    localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    typedef enum logic [REG_SEL_W-1:0] {
        REG_ROW0_COLS01,
        REG_ROW0_COLS23,
        REG_ROW1_COLS01,
        REG_ROW1_COLS23,
        REG_ROW2_COLS01,
        REG_ROW2_COLS23,
        REG_ROW3_COLS01,
        REG_ROW3_COLS23
    } reg_idx_t;

    typedef struct packed {
        logic en1;
        logic en2;
        logic en3;
    } pipe_ctrl_t;

    typedef struct packed {
        coord_t value;
        logic   ovf;
    } lane_result_t;

    // identity matrix with one at the given fraction width
    function automatic logic [CFG_DATA_W-1:0] cfg_reset_value(reg_idx_t idx, int frac);
        logic [CFG_DATA_W-1:0] one;
        logic [CFG_DATA_W-1:0] val;
        one = CFG_DATA_W'(1) << frac;
        case (idx)
            REG_ROW0_COLS01: val = one;
            REG_ROW1_COLS01: val = one << COORD_W;
            REG_ROW2_COLS23: val = one;
            REG_ROW3_COLS23: val = one << COORD_W;
            default:         val = '0;
        endcase
        return val;
    endfunction

endpackage

// ===== rtl/vmt_if.sv =====
// ----------------------------------------------------------------------------
// vmt interfaces
// Valid/ready channels for vertex words, result words and register writes.
// ----------------------------------------------------------------------------
interface vmt_vertex_if;
    import vmt_pkg::*;

    logic   valid;
    logic   ready;
    coord_t in_x;
    coord_t in_y;
    coord_t in_z;
    coord_t in_w;

    modport source (output valid, in_x, in_y, in_z, in_w, input ready);
    modport sink   (input valid, in_x, in_y, in_z, in_w, output ready);
endinterface

interface vmt_result_if;
    import vmt_pkg::*;

    logic   valid;
    logic   ready;
    coord_t out_x;
    coord_t out_y;
    coord_t out_z;
    coord_t out_w;
    logic   overflow;

    modport source (output valid, out_x, out_y, out_z, out_w, overflow, input ready);
    modport sink   (input valid, out_x, out_y, out_z, out_w, overflow, output ready);
endinterface

interface vmt_cfg_if;
    import vmt_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/vmt_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// vmt_cfg_regs
// Matrix coefficient registers, written through the register channel.
// ----------------------------------------------------------------------------
module vmt_cfg_regs #(
    parameter int FRAC_BITS = vmt_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    vmt_cfg_if.sink                           cfg,
    output vmt_pkg::vec4_t [vmt_pkg::NUM_COLS-1:0] matrix
);
    import vmt_pkg::*;

    logic [CFG_DATA_W-1:0] regs_reg [NUM_REGS];
    logic                  wr_en;

    assign cfg.ready = 1'b1;
    assign wr_en     = cfg.valid && (cfg.index < CFG_INDEX_W'(NUM_REGS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                regs_reg[i] <= cfg_reset_value(reg_idx_t'(i), FRAC_BITS);
            end
        end
        else if (wr_en)
        begin
            regs_reg[cfg.index[REG_SEL_W-1:0]] <= cfg.data;
        end
    end

    always_comb
    begin
        for (int r = 0; r < NUM_COLS; r++)
        begin
            matrix[r][0] = coord_t'(regs_reg[2*r][COORD_W-1:0]);
            matrix[r][1] = coord_t'(regs_reg[2*r][CFG_DATA_W-1:COORD_W]);
            matrix[r][2] = coord_t'(regs_reg[2*r+1][COORD_W-1:0]);
            matrix[r][3] = coord_t'(regs_reg[2*r+1][CFG_DATA_W-1:COORD_W]);
        end
    end

endmodule

// ===== rtl/vmt_lane.sv =====
// ----------------------------------------------------------------------------
// vmt_lane
// One output component: four products, pairwise sums, final sum, floor shift
// and saturation, three register stages.
// ----------------------------------------------------------------------------
module vmt_lane #(
    parameter int FRAC_BITS = vmt_pkg::FRAC_BITS_DEF
) (
    input  logic                  clk,
    input  vmt_pkg::pipe_ctrl_t   ctrl,
    input  vmt_pkg::vec4_t        coef,
    input  vmt_pkg::vec4_t        vert,
    output vmt_pkg::lane_result_t res
);
    import vmt_pkg::*;

    logic signed [PROD_W-1:0]    prod_reg [NUM_COLS];
    logic signed [PAIR_W-1:0]    pair_reg [2];
    lane_result_t                res_reg;

    logic signed [SUM_W-1:0]     sum;
    logic signed [SUM_W-1:0]     shifted;
    logic [SUM_W-COORD_W:0]      hi_bits;
    lane_result_t                res_next;

    always_ff @(posedge clk)
    begin
        if (ctrl.en1)
        begin
            for (int c = 0; c < NUM_COLS; c++)
            begin
                prod_reg[c] <= coord_t'(coef[c]) * coord_t'(vert[c]);
            end
        end
        if (ctrl.en2)
        begin
            pair_reg[0] <= PAIR_W'(prod_reg[0]) + PAIR_W'(prod_reg[1]);
            pair_reg[1] <= PAIR_W'(prod_reg[2]) + PAIR_W'(prod_reg[3]);
        end
        if (ctrl.en3)
        begin
            res_reg <= res_next;
        end
    end

    always_comb
    begin
        sum     = SUM_W'(pair_reg[0]) + SUM_W'(pair_reg[1]);
        shifted = sum >>> FRAC_BITS;
        hi_bits = shifted[SUM_W-1:COORD_W-1];
        if (!shifted[SUM_W-1] && (|hi_bits))
        begin
            res_next.value = COORD_MAX;
            res_next.ovf   = 1'b1;
        end
        else if (shifted[SUM_W-1] && !(&hi_bits))
        begin
            res_next.value = COORD_MIN;
            res_next.ovf   = 1'b1;
        end
        else
        begin
            res_next.value = coord_t'(shifted[COORD_W-1:0]);
            res_next.ovf   = 1'b0;
        end
    end

    assign res = res_reg;

endmodule

// ===== rtl/vmt_merge.sv =====
// ----------------------------------------------------------------------------
// vmt_merge
// Joins the four lane results into one result word and holds it in the
// output register until taken.
// ----------------------------------------------------------------------------
module vmt_merge (
    input  logic                  clk,
    input  logic                  rst_n,
    input  vmt_pkg::lane_result_t lane_res [vmt_pkg::NUM_COLS],
    input  logic                  res_valid,
    output logic                  take,
    vmt_result_if.source          result_out
);
    import vmt_pkg::*;

    logic   out_valid_reg;
    coord_t out_x_reg;
    coord_t out_y_reg;
    coord_t out_z_reg;
    coord_t out_w_reg;
    logic   overflow_reg;

    assign take = !out_valid_reg || result_out.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && res_valid)
        begin
            out_x_reg    <= lane_res[0].value;
            out_y_reg    <= lane_res[1].value;
            out_z_reg    <= lane_res[2].value;
            out_w_reg    <= lane_res[3].value;
            overflow_reg <= lane_res[0].ovf | lane_res[1].ovf
                          | lane_res[2].ovf | lane_res[3].ovf;
        end
    end

    assign result_out.valid    = out_valid_reg;
    assign result_out.out_x    = out_x_reg;
    assign result_out.out_y    = out_y_reg;
    assign result_out.out_z    = out_z_reg;
    assign result_out.out_w    = out_w_reg;
    assign result_out.overflow = overflow_reg;

endmodule

// ===== rtl/vertex_matrix_transform.sv =====
// ----------------------------------------------------------------------------
// vertex_matrix_transform
// 4x4 fixed-point matrix times homogeneous vertex, four lanes in parallel.
// ----------------------------------------------------------------------------
// One vertex word is accepted per clock and one result word leaves per clock,
// sustained while result_out.ready holds high; a vertex passes the product,
// pair-sum and lane result registers, then the output register. Sixteen 32x32
// multipliers, one per coefficient, feed four lanes of pairwise and final
// adders, each stage with its own valid bit, so up to three more vertices
// still enter while a result waits in the output register. Each component is
// the exact sum of four products, floored by FRAC_BITS and saturated to 32
// bits signed; overflow flags any saturated component. Register writes are
// always taken, and belong between vertex streams.
// ----------------------------------------------------------------------------
module vertex_matrix_transform #(
    parameter int FRAC_BITS = vmt_pkg::FRAC_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    vmt_vertex_if.sink   vertex_in,
    vmt_result_if.source result_out,
    vmt_cfg_if.sink      cfg
);
    import vmt_pkg::*;

    vec4_t [NUM_COLS-1:0] matrix;
    vec4_t                vert;
    lane_result_t         lane_res [NUM_COLS];
    pipe_ctrl_t           ctrl;
    logic                 take;
    logic                 v1_reg;
    logic                 v2_reg;
    logic                 v3_reg;

    assign vert = {vertex_in.in_w, vertex_in.in_z, vertex_in.in_y, vertex_in.in_x};

    // per-stage advance, a stage moves when empty or when the next one moves
    assign ctrl.en3       = !v3_reg || take;
    assign ctrl.en2       = !v2_reg || ctrl.en3;
    assign ctrl.en1       = !v1_reg || ctrl.en2;
    assign vertex_in.ready = ctrl.en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.en1)
            begin
                v1_reg <= vertex_in.valid;
            end
            if (ctrl.en2)
            begin
                v2_reg <= v1_reg;
            end
            if (ctrl.en3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    vmt_cfg_regs #(
        .FRAC_BITS (FRAC_BITS)
    ) u_cfg_regs (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .matrix (matrix)
    );

    for (genvar r = 0; r < NUM_COLS; r++)
    begin : g_lane
        vmt_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .clk  (clk),
            .ctrl (ctrl),
            .coef (matrix[r]),
            .vert (vert),
            .res  (lane_res[r])
        );
    end

    vmt_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .lane_res   (lane_res),
        .res_valid  (v3_reg),
        .take       (take),
        .result_out (result_out)
    );

    a_accept_fills_stage1: assert property (@(posedge clk) disable iff (!rst_n)
        (vertex_in.valid && vertex_in.ready) |=> v1_reg)
        else $error("accepted vertex not in first stage");

    a_stall_holds_last_stage: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && !take) |=> v3_reg)
        else $error("stalled lane result dropped");

    a_overflow_means_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        (result_out.valid && result_out.overflow) |->
            (result_out.out_x == COORD_MAX || result_out.out_x == COORD_MIN ||
             result_out.out_y == COORD_MAX || result_out.out_y == COORD_MIN ||
             result_out.out_z == COORD_MAX || result_out.out_z == COORD_MIN ||
             result_out.out_w == COORD_MAX || result_out.out_w == COORD_MIN))
        else $error("overflow flag without saturated component");

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench for vertex_matrix_transform
// Streams vertex words through the 4x4 fixed-point transform under several
// matrices (identity, extremes, random, small, sparse); each result word is
// checked against its directed answer or a local exact sum, floor and clamp.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import vmt_pkg::*;

    localparam int     FRAC               = FRAC_BITS_DEF;
    localparam coord_t FIX_ONE            = coord_t'(1 << FRAC);
    localparam int     CYCLE_LIMIT        = 1_000_000;
    localparam int     PHASES             = 14;
    localparam int     VERTICES_PER_PHASE = 125;
    localparam int     SETTLE_CYCLES      = 8;
    localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = CFG_INDEX_W'(NUM_REGS);

    typedef struct packed {
        vec4_t comp;
        logic  ovf;
    } xform_t;

    typedef enum logic [1:0] {
        ROW_VERTEX,
        ROW_WRITE,
        ROW_FILL
    } row_kind_t;

    typedef enum int {
        MAT_IDENTITY,
        MAT_FULL,
        MAT_SMALL,
        MAT_EXTREME,
        MAT_SPARSE
    } matrix_kind_t;

    typedef struct {
        row_kind_t              kind;
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  data;
        vec4_t                  vtx;
        bit                     typed;
        xform_t                 want;
    } stim_row_t;

    logic clk;
    logic rst_n;

    vmt_vertex_if vtx_ch();
    vmt_result_if res_ch();
    vmt_cfg_if    cfg_ch();

    vertex_matrix_transform dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .vertex_in  (vtx_ch),
        .result_out (res_ch),
        .cfg        (cfg_ch)
    );

    logic [CFG_DATA_W-1:0] coeff_regs [NUM_REGS];
    xform_t                pending_results [$];
    bit                    fixed_answer_on;
    xform_t                fixed_answer;
    int                    error_count;
    int                    cycle_count;
    int                    ready_hold;
    string                 lane_name [NUM_COLS] = '{"out_x", "out_y", "out_z", "out_w"};

    always #4 clk = ~clk;

    function automatic vec4_t make_vec(coord_t x, coord_t y, coord_t z, coord_t w);
        vec4_t v;
        v[0] = x;
        v[1] = y;
        v[2] = z;
        v[3] = w;
        return v;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] identity_reg(int idx);
        int                    row;
        logic [CFG_DATA_W-1:0] one_word;
        row      = idx / 2;
        one_word = CFG_DATA_W'(1) << FRAC;
        if (row / 2 != idx % 2)
            return '0;
        return (row % 2) ? (one_word << COORD_W) : one_word;
    endfunction

    // exact 66-bit sum of four products, floored and clamped per lane
    function automatic xform_t transform_vertex(vec4_t v);
        xform_t                  res;
        logic signed [SUM_W-1:0] acc;
        logic signed [PROD_W-1:0] prod;
        logic [CFG_DATA_W-1:0]   pair;
        coord_t                  coef;
        coord_t                  comp;
        res.ovf = 1'b0;
        for (int r = 0; r < NUM_COLS; r++)
        begin
            acc = '0;
            for (int c = 0; c < NUM_COLS; c++)
            begin
                pair = coeff_regs[r * 2 + c / 2];
                coef = (c % 2) ? coord_t'(pair[CFG_DATA_W-1:COORD_W])
                               : coord_t'(pair[COORD_W-1:0]);
                comp = v[c];
                prod = $signed(coef) * $signed(comp);
                acc  = acc + prod;
            end
            acc = acc >>> FRAC;
            if (acc > COORD_MAX)
            begin
                res.comp[r] = COORD_MAX;
                res.ovf     = 1'b1;
            end
            else if (acc < COORD_MIN)
            begin
                res.comp[r] = COORD_MIN;
                res.ovf     = 1'b1;
            end
            else
                res.comp[r] = coord_t'(acc[COORD_W-1:0]);
        end
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic coord_t extreme_value();
        case ($urandom_range(0, 6))
            0: return COORD_MAX;
            1: return COORD_MIN;
            2: return '0;
            3: return FIX_ONE;
            4: return -FIX_ONE;
            5: return coord_t'(1);
            default: return coord_t'(-1);
        endcase
    endfunction

    function automatic coord_t random_component();
        int r;
        int s;
        r = $urandom_range(0, 9);
        s = int'($urandom_range(0, 1 << 25)) - (1 << 24);
        if (r < 4)
            return coord_t'($urandom);
        if (r < 8)
            return coord_t'(s);
        return extreme_value();
    endfunction

    function automatic coord_t random_coeff(matrix_kind_t kind);
        int s;
        s = int'($urandom_range(0, 1 << 19)) - (1 << 18);
        case (kind)
            MAT_SMALL:   return coord_t'(s);
            MAT_EXTREME: return extreme_value();
            MAT_SPARSE:  return ($urandom_range(0, 3) == 0) ? coord_t'($urandom) : '0;
            default:     return coord_t'($urandom);
        endcase
    endfunction

    function automatic stim_row_t vertex_row(vec4_t v, bit typed, vec4_t want_v,
                                             logic want_ovf);
        stim_row_t row;
        row.kind  = ROW_VERTEX;
        row.index = '0;
        row.data  = '0;
        row.vtx   = v;
        row.typed = typed;
        row.want  = {want_v, want_ovf};
        return row;
    endfunction

    function automatic stim_row_t write_row(row_kind_t kind, logic [CFG_INDEX_W-1:0] idx,
                                           logic [CFG_DATA_W-1:0] data);
        stim_row_t row;
        row.kind  = kind;
        row.index = idx;
        row.data  = data;
        row.vtx   = '0;
        row.typed = 1'b0;
        row.want  = '0;
        return row;
    endfunction

    task automatic send_vertex(vec4_t v, bit typed, xform_t want);
        vtx_ch.valid    = 1'b1;
        vtx_ch.in_x     = v[0];
        vtx_ch.in_y     = v[1];
        vtx_ch.in_z     = v[2];
        vtx_ch.in_w     = v[3];
        fixed_answer_on = typed;
        fixed_answer    = want;
        @(posedge clk);
        while (!vtx_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic sender_gap(bit steady);
        int n;
        n = steady ? 0 : pick_gap();
        if (n > 0)
        begin
            vtx_ch.valid = 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    task automatic wait_idle();
        vtx_ch.valid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = data;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // result stalls: runs of ready, occasional long stretches without a stall
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (ready_hold > 0)
                ready_hold--;
            else if (res_ch.ready)
            begin
                ready_hold = pick_gap();
                if (ready_hold > 0)
                begin
                    res_ch.ready = 1'b0;
                    ready_hold--;
                end
            end
            else
            begin
                res_ch.ready = 1'b1;
                ready_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                         : $urandom_range(0, 12);
            end
        end
    end

    always @(posedge clk)
    begin : word_monitor
        xform_t got;
        xform_t want;
        if (rst_n)
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                got.comp[0] = res_ch.out_x;
                got.comp[1] = res_ch.out_y;
                got.comp[2] = res_ch.out_z;
                got.comp[3] = res_ch.out_w;
                got.ovf     = res_ch.overflow;
                if (pending_results.size() == 0)
                begin
                    $error("result word with nothing pending: %0d %0d %0d %0d ovf %0b",
                           got.comp[0], got.comp[1], got.comp[2], got.comp[3], got.ovf);
                    error_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    for (int c = 0; c < NUM_COLS; c++)
                    begin
                        if (got.comp[c] !== want.comp[c])
                        begin
                            $error("%s: expected %0d, got %0d", lane_name[c],
                                   want.comp[c], got.comp[c]);
                            error_count++;
                        end
                    end
                    if (got.ovf !== want.ovf)
                    begin
                        $error("overflow: expected %0b, got %0b", want.ovf, got.ovf);
                        error_count++;
                    end
                end
            end
            if (cfg_ch.valid && cfg_ch.ready && cfg_ch.index < NUM_REGS)
                coeff_regs[cfg_ch.index[REG_SEL_W-1:0]] = cfg_ch.data;
            if (vtx_ch.valid && vtx_ch.ready)
            begin
                if (fixed_answer_on)
                    pending_results.push_back(fixed_answer);
                else
                    pending_results.push_back(
                        transform_vertex(make_vec(vtx_ch.in_x, vtx_ch.in_y,
                                                  vtx_ch.in_z, vtx_ch.in_w)));
            end
        end
    end

    initial
    begin : stimulus
        stim_row_t             directed_rows [$];
        stim_row_t             row;
        vec4_t                 v;
        matrix_kind_t          kind;
        bit                    steady;
        logic [CFG_DATA_W-1:0] word;

        clk             = 1'b0;
        rst_n           = 1'b0;
        error_count     = 0;
        cycle_count     = 0;
        ready_hold      = 0;
        fixed_answer_on = 1'b0;
        fixed_answer    = '0;
        vtx_ch.valid    = 1'b0;
        vtx_ch.in_x     = '0;
        vtx_ch.in_y     = '0;
        vtx_ch.in_z     = '0;
        vtx_ch.in_w     = '0;
        res_ch.ready    = 1'b0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = '0;
        cfg_ch.data     = '0;
        for (int i = 0; i < NUM_REGS; i++)
            coeff_regs[i] = identity_reg(i);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // identity after reset passes every vertex through unchanged
        v = make_vec(0, 0, 0, 0);
        directed_rows.push_back(vertex_row(v, 1, v, 0));
        v = make_vec(COORD_MAX, COORD_MIN, 1, -1);
        directed_rows.push_back(vertex_row(v, 1, v, 0));
        v = make_vec(COORD_MIN, COORD_MAX, -1, FIX_ONE);
        directed_rows.push_back(vertex_row(v, 1, v, 0));
        v = make_vec(32'h0000FFFF, 32'hFFFF0000, 32'h5555AAAA, 32'hAAAA5555);
        directed_rows.push_back(vertex_row(v, 1, v, 0));
        // write past the last register is dropped
        directed_rows.push_back(write_row(ROW_WRITE, REG_UNMAPPED, '1));
        v = make_vec(1, 2, 3, 4);
        directed_rows.push_back(vertex_row(v, 1, v, 0));
        // largest positive coefficients everywhere
        directed_rows.push_back(write_row(ROW_FILL, '0, {COORD_MAX, COORD_MAX}));
        directed_rows.push_back(vertex_row(make_vec(COORD_MAX, COORD_MAX, COORD_MAX,
                                                    COORD_MAX), 1,
                                           make_vec(COORD_MAX, COORD_MAX, COORD_MAX,
                                                    COORD_MAX), 1));
        directed_rows.push_back(vertex_row(make_vec(COORD_MIN, COORD_MIN, COORD_MIN,
                                                    COORD_MIN), 1,
                                           make_vec(COORD_MIN, COORD_MIN, COORD_MIN,
                                                    COORD_MIN), 1));
        directed_rows.push_back(vertex_row(make_vec(1, 0, 0, 0), 1,
                                           make_vec(32767, 32767, 32767, 32767), 0));
        // floor toward minus infinity, not toward zero
        directed_rows.push_back(vertex_row(make_vec(-1, 0, 0, 0), 1,
                                           make_vec(-32768, -32768, -32768, -32768), 0));
        directed_rows.push_back(vertex_row(make_vec(COORD_MAX, COORD_MIN, COORD_MAX,
                                                    COORD_MIN), 0, '0, 0));
        // most negative coefficients everywhere
        directed_rows.push_back(write_row(ROW_FILL, '0, {COORD_MIN, COORD_MIN}));
        directed_rows.push_back(vertex_row(make_vec(COORD_MIN, COORD_MIN, COORD_MIN,
                                                    COORD_MIN), 1,
                                           make_vec(COORD_MAX, COORD_MAX, COORD_MAX,
                                                    COORD_MAX), 1));
        directed_rows.push_back(vertex_row(make_vec(COORD_MAX, COORD_MAX, COORD_MAX,
                                                    COORD_MAX), 1,
                                           make_vec(COORD_MIN, COORD_MIN, COORD_MIN,
                                                    COORD_MIN), 1));
        directed_rows.push_back(write_row(ROW_WRITE, CFG_INDEX_W'(REG_ROW0_COLS01),
                                          {-FIX_ONE, FIX_ONE}));
        directed_rows.push_back(write_row(ROW_WRITE, CFG_INDEX_W'(REG_ROW3_COLS23), '0));
        directed_rows.push_back(vertex_row(make_vec(FIX_ONE, FIX_ONE, 0, 0), 0, '0, 0));
        directed_rows.push_back(vertex_row(make_vec(FIX_ONE, -FIX_ONE, 0, COORD_MAX),
                                           0, '0, 0));

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            case (row.kind)
                ROW_VERTEX:
                begin
                    send_vertex(row.vtx, row.typed, row.want);
                    sender_gap(1'b0);
                end
                ROW_WRITE:
                begin
                    wait_idle();
                    write_reg(row.index, row.data);
                end
                default:
                begin
                    wait_idle();
                    for (int r = 0; r < NUM_REGS; r++)
                        write_reg(CFG_INDEX_W'(r), row.data);
                end
            endcase
        end

        for (int p = 0; p < PHASES; p++)
        begin
            wait_idle();
            kind   = (p < 5) ? matrix_kind_t'(p) : matrix_kind_t'($urandom_range(0, 4));
            steady = ($urandom_range(0, 3) == 0);
            for (int r = 0; r < NUM_REGS; r++)
            begin
                word = (kind == MAT_IDENTITY) ? identity_reg(r)
                                              : {random_coeff(kind), random_coeff(kind)};
                write_reg(CFG_INDEX_W'(r), word);
            end
            if ($urandom_range(0, 2) == 0)
                write_reg(CFG_INDEX_W'($urandom_range(NUM_REGS, (1 << CFG_INDEX_W) - 1)),
                          {$urandom, $urandom});
            for (int n = 0; n < VERTICES_PER_PHASE; n++)
            begin
                v = make_vec(random_component(), random_component(), random_component(),
                             ($urandom_range(0, 2) == 0) ? FIX_ONE : random_component());
                send_vertex(v, 1'b0, '0);
                if ($urandom_range(0, 199) == 0)
                    wait_idle();
                else
                    sender_gap(steady);
            end
        end

        wait_idle();
        repeat (16) @(posedge clk);
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
